@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the arc tessellation RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ATPV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("atpv assertion failed");
`define ATPV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("atpv implication failed");
`define ATPV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("atpv next-cycle implication failed");
`else
`define ATPV_ASSERT(lbl, clk, rstn, prop)
`define ATPV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ATPV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/atpv_pkg.sv @@
// ----------------------------------------------------------------------------
// atpv_pkg
// Types, constants and the arctangent table of the arc tessellation block.
// ----------------------------------------------------------------------------
`default_nettype none
package atpv_pkg;

    localparam int XY_W         = 28;
    localparam int Z_W          = 34;
    localparam int GAIN_W       = 33;
    localparam int PROD_W       = XY_W + GAIN_W;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int SWEEP4_W     = 18;

    localparam logic signed [Z_W-1:0]    QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [GAIN_W-1:0] GAIN_COMP    = 33'sd2608131496;

    typedef struct packed {
        logic signed [31:0] focal_x;
        logic signed [31:0] focal_y;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [15:0]        sweep_angle;
        logic [30:0]        arc_radius;
        logic [4:0]         segment_count;
    } arc_in_t;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [3:0]         vertex_index;
        logic               last_vertex;
    } vertex_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ANGLE,
        ST_CORDIC,
        ST_GAIN_X,
        ST_GAIN_Y,
        ST_RAD_X,
        ST_RAD_Y,
        ST_SUM,
        ST_OUT
    } state_t;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] k);
        logic signed [Z_W-1:0] v;
        case (k)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933405;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10680862;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335086;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41721;
            5'd15:   v = 34'sd20860;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2607;
            5'd19:   v = 34'sd1303;
            5'd20:   v = 34'sd651;
            5'd21:   v = 34'sd325;
            5'd22:   v = 34'sd162;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/atpv_div.sv @@
// ----------------------------------------------------------------------------
// atpv_div
// Restoring divider, one quotient bit per cycle, for the angle step.
// ----------------------------------------------------------------------------
`default_nettype none
module atpv_div #(
    parameter int DV_W = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [atpv_pkg::SWEEP4_W-1:0] dividend,
    input  wire logic [DV_W-1:0]               divisor,
    output logic                               done,
    output logic [atpv_pkg::SWEEP4_W-1:0]      quotient,
    output logic [DV_W-1:0]                    remainder
);
    import atpv_pkg::*;

    logic [SWEEP4_W-1:0] quo_reg, quo_next;
    logic [DV_W-1:0]     rem_reg, rem_next;
    logic [DV_W-1:0]     dvs_reg;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DV_W:0]       trial;
    logic [DV_W:0]       diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[SWEEP4_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DV_W-1:0];
                quo_next = {quo_reg[SWEEP4_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DV_W-1:0];
                quo_next = {quo_reg[SWEEP4_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(SWEEP4_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ hw/rtl/atpv_cordic.sv @@
// ----------------------------------------------------------------------------
// atpv_cordic
// Iterative rotation CORDIC with quadrant pre-rotation, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module atpv_cordic (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [atpv_pkg::XY_W-1:0]  x_in,
    input  wire logic signed [atpv_pkg::XY_W-1:0]  y_in,
    input  wire logic signed [atpv_pkg::Z_W-1:0]   z_in,
    output logic                                   done,
    output logic signed [atpv_pkg::XY_W-1:0]       x_out,
    output logic signed [atpv_pkg::XY_W-1:0]       y_out
);
    import atpv_pkg::*;

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [STEP_W-1:0]      k_reg, k_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;

    always_comb begin
        dx        = y_reg >>> k_reg;
        dy        = x_reg >>> k_reg;
        at        = atan_lut(k_reg);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            k_next    = '0;
            busy_next = 1'b1;
            if (z_in > QUARTER_TURN) begin
                x_next = -y_in;
                y_next = x_in;
                z_next = z_in - QUARTER_TURN;
            end else if (z_in < -QUARTER_TURN) begin
                x_next = y_in;
                y_next = -x_in;
                z_next = z_in + QUARTER_TURN;
            end else begin
                x_next = x_in;
                y_next = y_in;
                z_next = z_in;
            end
        end else if (busy_reg) begin
            if (!z_reg[Z_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            k_next = k_reg + 5'd1;
            if (k_reg == 5'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule
`default_nettype wire

@@ hw/rtl/atpv_mul.sv @@
// ----------------------------------------------------------------------------
// atpv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module atpv_mul (
    input  wire logic                                aclk,
    input  wire logic signed [atpv_pkg::XY_W-1:0]    a,
    input  wire logic signed [atpv_pkg::GAIN_W-1:0]  b,
    output logic signed [atpv_pkg::PROD_W-1:0]       prod
);
    import atpv_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ hw/rtl/arc_to_polygon_vertices.sv @@
// ----------------------------------------------------------------------------
// arc_to_polygon_vertices
// Tessellates one arc per input transaction into a run of polygon vertices.
// ----------------------------------------------------------------------------
// Each input transaction describes an arc; the block emits between 2 and
// MAX_VERTICES result transactions, one per vertex, spread evenly over the
// sweep and symmetric about the axis, the final one flagged by last_vertex.
// The block handles one arc at a time and is not ready while it works. An
// arc first runs the serial divider that forms the angle step (18 quotient
// bits, one per cycle); then each vertex forms its angle, runs the CORDIC
// rotation (24 steps of the shared shift and add unit), passes through the
// shared multiplier for gain removal and radius scaling, and ends in the
// result transaction, which waits while the consumer holds m_ready low.
`default_nettype none
`include "assert_macros.svh"
module arc_to_polygon_vertices #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire atpv_pkg::arc_in_t     s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output atpv_pkg::vertex_out_t      m_data
);
    import atpv_pkg::*;

    // d = n-1 never exceeds MAX_VERTICES-1; the divisor is 2d.
    localparam int D_W  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int DV_W = D_W + 1;
    localparam int IW   = (D_W > 4) ? D_W : 4;

    state_t state_reg, state_next;

    arc_in_t                arc_reg;
    logic [D_W-1:0]         d_reg;
    logic [SWEEP4_W-1:0]    qstep_reg, q_reg;
    logic [DV_W-1:0]        rstep_reg, r_reg;
    logic [IW-1:0]          i_reg;
    logic signed [XY_W-1:0] gx_reg, gy_reg;
    logic signed [38:0]     rx_reg;
    vertex_out_t            out_reg;

    logic [7:0]             n_clamp;
    logic [7:0]             d_full;
    logic [D_W-1:0]         d_in;
    logic                   div_start, div_done;
    logic [SWEEP4_W-1:0]    div_q;
    logic [DV_W-1:0]        div_r;
    logic                   cordic_start, cordic_done;
    logic signed [XY_W-1:0] cx, cy, ax_s, ay_s;
    logic signed [18:0]     ang_diff;
    logic signed [Z_W-1:0]  ang;
    logic signed [XY_W-1:0] mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] gain_rnd, rad_rnd;
    logic signed [39:0]     sum_x, sum_y;
    logic signed [31:0]     sat_x, sat_y;
    logic                   is_last;
    logic [SWEEP4_W-1:0]    q_adv;
    logic [DV_W:0]          r_sum;
    logic [DV_W:0]          two_d;

    // Clamp the requested count to 2..MAX_VERTICES.
    always_comb begin
        if (s_data.segment_count < 5'd2) begin
            n_clamp = 8'd2;
        end else if ({3'b000, s_data.segment_count} > 8'(MAX_VERTICES)) begin
            n_clamp = 8'(MAX_VERTICES);
        end else begin
            n_clamp = {3'b000, s_data.segment_count};
        end
        d_full = n_clamp - 8'd1;
        d_in   = d_full[D_W-1:0];
    end

    // Angle of the current vertex in 2^-32 turn units: (q - sweep) * 2^15.
    assign ang_diff = $signed({1'b0, q_reg}) - $signed({3'b000, arc_reg.sweep_angle});
    assign ang      = {ang_diff, 15'd0};
    assign ax_s     = {{(XY_W-24){arc_reg.axis_x[15]}}, arc_reg.axis_x, 8'd0};
    assign ay_s     = {{(XY_W-24){arc_reg.axis_y[15]}}, arc_reg.axis_y, 8'd0};

    atpv_div #(.DV_W(DV_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  ({s_data.sweep_angle, 2'b00}),
        .divisor   ({d_in, 1'b0}),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    atpv_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (ax_s),
        .y_in    (ay_s),
        .z_in    (ang),
        .done    (cordic_done),
        .x_out   (cx),
        .y_out   (cy)
    );

    atpv_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Rounding of the registered product, ties toward plus infinity.
    assign gain_rnd = (prod + (PROD_W'(1) <<< 31)) >>> 32;
    assign rad_rnd  = (prod + (PROD_W'(1) <<< 21)) >>> 22;

    always_comb begin
        sum_x = {rx_reg[38], rx_reg} + {{8{arc_reg.focal_x[31]}}, arc_reg.focal_x};
        sum_y = {rad_rnd[38], rad_rnd[38:0]} + {{8{arc_reg.focal_y[31]}}, arc_reg.focal_y};
        if (sum_x > 40'sd2147483647) begin
            sat_x = 32'sh7FFFFFFF;
        end else if (sum_x < -40'sd2147483648) begin
            sat_x = 32'sh80000000;
        end else begin
            sat_x = sum_x[31:0];
        end
        if (sum_y > 40'sd2147483647) begin
            sat_y = 32'sh7FFFFFFF;
        end else if (sum_y < -40'sd2147483648) begin
            sat_y = 32'sh80000000;
        end else begin
            sat_y = sum_y[31:0];
        end
    end

    // Next vertex: numerator grows by 4*sweep = qstep*2d + rstep.
    always_comb begin
        is_last = (i_reg == IW'(d_reg));
        two_d   = {1'b0, d_reg, 1'b0};
        r_sum   = {1'b0, r_reg} + {1'b0, rstep_reg};
        q_adv   = q_reg + qstep_reg;
        if (r_sum >= two_d) begin
            q_adv = q_reg + qstep_reg + SWEEP4_W'(1);
            r_sum = r_sum - two_d;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_ANGLE;
            ST_ANGLE:  state_next = ST_CORDIC;
            ST_CORDIC: if (cordic_done) state_next = ST_GAIN_X;
            ST_GAIN_X: state_next = ST_GAIN_Y;
            ST_GAIN_Y: state_next = ST_RAD_X;
            ST_RAD_X:  state_next = ST_RAD_Y;
            ST_RAD_Y:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = out_reg.last_vertex ? ST_IDLE : ST_ANGLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output and operand-select logic.
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        div_start    = 1'b0;
        cordic_start = 1'b0;
        mul_a        = gx_reg;
        mul_b        = $signed({2'b00, arc_reg.arc_radius});
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid;
            end
            ST_ANGLE:  cordic_start = 1'b1;
            ST_GAIN_X: begin
                mul_a = cx;
                mul_b = GAIN_COMP;
            end
            ST_GAIN_Y: begin
                mul_a = cy;
                mul_b = GAIN_COMP;
            end
            ST_RAD_X:  mul_a = gx_reg;
            ST_RAD_Y:  mul_a = gy_reg;
            ST_OUT:    m_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers; payload only, no reset needed.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    arc_reg <= s_data;
                    d_reg   <= d_in;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    qstep_reg <= div_q;
                    rstep_reg <= div_r;
                    q_reg     <= '0;
                    r_reg     <= DV_W'(d_reg);
                    i_reg     <= '0;
                end
            end
            ST_GAIN_Y: gx_reg <= gain_rnd[XY_W-1:0];
            ST_RAD_X:  gy_reg <= gain_rnd[XY_W-1:0];
            ST_RAD_Y:  rx_reg <= rad_rnd[38:0];
            ST_SUM: begin
                out_reg.vertex_x     <= sat_x;
                out_reg.vertex_y     <= sat_y;
                out_reg.vertex_index <= i_reg[3:0];
                out_reg.last_vertex  <= is_last;
            end
            ST_OUT: begin
                if (m_ready && !out_reg.last_vertex) begin
                    q_reg <= q_adv;
                    r_reg <= r_sum[DV_W-1:0];
                    i_reg <= i_reg + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_data = out_reg;

    `ATPV_ASSERT_IMP(a_cordic_done_owned, aclk, aresetn, cordic_done, state_reg == ST_CORDIC)
    `ATPV_ASSERT_IMP(a_div_done_owned, aclk, aresetn, div_done, state_reg == ST_DIV)
    `ATPV_ASSERT_NXT(a_last_frees_input, aclk, aresetn, m_valid && m_ready && m_data.last_vertex, s_ready)
    `ATPV_ASSERT_IMP(a_index_in_range, aclk, aresetn, m_valid, i_reg <= IW'(d_reg))

endmodule
`default_nettype wire
